// ===== rtl/core/psqc_pkg.sv =====
// ----------------------------------------------------------------------------
// psqc_pkg
// Shared types and constants of the periodic signal quality checker.
// ----------------------------------------------------------------------------
package psqc_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int TIME_BITS_DEF   = 32;

  localparam int SPW_W      = 7;
  localparam int INTERVAL_W = 16;
  localparam int AMP_W      = 12;
  localparam int PCT_W      = 7;
  localparam int COUNT_W    = 16;
  localparam int POS_W      = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
  localparam logic [PCT_W-1:0]   PERCENT_SCALE = 7'd100;

  localparam logic [SPW_W-1:0]      SPW_RST     = 7'd20;
  localparam logic [INTERVAL_W-1:0] MIN_INT_RST = 16'd900;
  localparam logic [INTERVAL_W-1:0] MAX_INT_RST = 16'd1100;
  localparam logic [AMP_W-1:0]      MIN_AMP_RST = 12'd100;
  localparam logic [AMP_W-1:0]      MAX_AMP_RST = 12'd250;
  localparam logic [PCT_W-1:0]      PCT_RST     = 7'd60;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLES_PER_WINDOW = 3'd0,
    REG_MIN_INTERVAL       = 3'd1,
    REG_MAX_INTERVAL       = 3'd2,
    REG_MIN_AMPLITUDE      = 3'd3,
    REG_MAX_AMPLITUDE      = 3'd4,
    REG_PASS_PERCENT       = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [SPW_W-1:0]      samples_per_window;
    logic [INTERVAL_W-1:0] min_interval_ms;
    logic [INTERVAL_W-1:0] max_interval_ms;
    logic [AMP_W-1:0]      min_amplitude;
    logic [AMP_W-1:0]      max_amplitude;
    logic [PCT_W-1:0]      pass_percent;
  } cfg_t;

endpackage

// ===== rtl/core/psqc_sample_if.sv =====
// ----------------------------------------------------------------------------
// psqc_sample_if
// Sample channel: one converter sample with its millisecond timestamp.
// ----------------------------------------------------------------------------
interface psqc_sample_if #(
  parameter int SAMPLE_BITS = psqc_pkg::SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = psqc_pkg::TIME_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic [TIME_BITS-1:0]   time_ms;

  modport source (output valid, output sample, output time_ms, input ready);
  modport sink   (input valid, input sample, input time_ms, output ready);
endinterface

// ===== rtl/core/psqc_result_if.sv =====
// ----------------------------------------------------------------------------
// psqc_result_if
// Result channel: period figures, counters and the pass verdict.
// ----------------------------------------------------------------------------
interface psqc_result_if #(
  parameter int SAMPLE_BITS = psqc_pkg::SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = psqc_pkg::TIME_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          period_done;
  logic                          period_valid;
  logic [SAMPLE_BITS-1:0]        first_amplitude;
  logic [SAMPLE_BITS-1:0]        second_amplitude;
  logic [TIME_BITS-1:0]          max_peak_interval;
  logic [TIME_BITS-1:0]          min_peak_interval;
  logic [psqc_pkg::COUNT_W-1:0]  total_periods;
  logic [psqc_pkg::COUNT_W-1:0]  good_periods;
  logic                          pass_verdict;

  modport source (output valid, output period_done, output period_valid,
                  output first_amplitude, output second_amplitude,
                  output max_peak_interval, output min_peak_interval,
                  output total_periods, output good_periods, output pass_verdict,
                  input ready);
  modport sink   (input valid, input period_done, input period_valid,
                  input first_amplitude, input second_amplitude,
                  input max_peak_interval, input min_peak_interval,
                  input total_periods, input good_periods, input pass_verdict,
                  output ready);
endinterface

// ===== rtl/core/psqc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// psqc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface psqc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [psqc_pkg::CFG_IDX_W-1:0]   index;
  logic [psqc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/psqc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// psqc_cfg_regs
// Configuration register file, written one register per transfer.
// ----------------------------------------------------------------------------
module psqc_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  psqc_cfg_if.sink       cfg,
  output psqc_pkg::cfg_t regs
);
  import psqc_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.samples_per_window <= SPW_RST;
      regs.min_interval_ms    <= MIN_INT_RST;
      regs.max_interval_ms    <= MAX_INT_RST;
      regs.min_amplitude      <= MIN_AMP_RST;
      regs.max_amplitude      <= MAX_AMP_RST;
      regs.pass_percent       <= PCT_RST;
    end else if (cfg.valid) begin
      // Indexes beyond the register list are accepted and dropped.
      unique case (cfg.index)
        REG_SAMPLES_PER_WINDOW: regs.samples_per_window <= cfg.data[SPW_W-1:0];
        REG_MIN_INTERVAL:       regs.min_interval_ms    <= cfg.data[INTERVAL_W-1:0];
        REG_MAX_INTERVAL:       regs.max_interval_ms    <= cfg.data[INTERVAL_W-1:0];
        REG_MIN_AMPLITUDE:      regs.min_amplitude      <= cfg.data[AMP_W-1:0];
        REG_MAX_AMPLITUDE:      regs.max_amplitude      <= cfg.data[AMP_W-1:0];
        REG_PASS_PERCENT:       regs.pass_percent       <= cfg.data[PCT_W-1:0];
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/core/psqc_in_stage.sv =====
// ----------------------------------------------------------------------------
// psqc_in_stage
// Input register: captures one sample and holds it until the tracker steps.
// ----------------------------------------------------------------------------
module psqc_in_stage #(
  parameter int SAMPLE_BITS = psqc_pkg::SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = psqc_pkg::TIME_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  psqc_sample_if.sink            samples,
  input  logic                   step,
  output logic                   held_valid,
  output logic [SAMPLE_BITS-1:0] held_sample,
  output logic [TIME_BITS-1:0]   held_time
);
  logic load;

  // The register refills in the same cycle that its item moves on.
  assign samples.ready = !held_valid || step;
  assign load          = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (step) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_sample <= samples.sample;
      held_time   <= samples.time_ms;
    end
  end
endmodule

// ===== rtl/core/psqc_tracker.sv =====
// ----------------------------------------------------------------------------
// psqc_tracker
// Window peak tracking, period evaluation, counters and the result register.
// ----------------------------------------------------------------------------
module psqc_tracker #(
  parameter int SAMPLE_BITS = psqc_pkg::SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = psqc_pkg::TIME_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  psqc_pkg::cfg_t         regs,
  input  logic                   step,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [TIME_BITS-1:0]   time_ms,
  input  logic                   res_take,
  output logic                   res_valid,
  psqc_result_if.source          results
);
  import psqc_pkg::*;

  localparam int CMP_W   = (SAMPLE_BITS > AMP_W) ? SAMPLE_BITS : AMP_W;
  localparam int PROD_W  = COUNT_W + PCT_W;

  typedef logic [SAMPLE_BITS-1:0] level_t;
  typedef logic [TIME_BITS-1:0]   stamp_t;

  // Window position and counters are control state; peaks are reloaded
  // whenever a period starts, so they need no reset.
  logic [POS_W-1:0]   pos, pos_next;
  logic [COUNT_W-1:0] total, total_next;
  logic [COUNT_W-1:0] good, good_next;

  level_t f_max, f_min, s_max, s_min;
  stamp_t f_max_t, f_min_t, s_max_t, s_min_t;
  level_t f_max_n, f_min_n, s_max_n, s_min_n;
  stamp_t f_max_t_n, f_min_t_n, s_max_t_n, s_min_t_n;

  logic [SPW_W-1:0]   spw;
  logic [POS_W-1:0]   two_spw;
  logic [POS_W-1:0]   pos_adv;
  logic               in_first, in_second, done, valid;
  level_t             amp0, amp1;
  stamp_t             imax, imin;
  logic [PROD_W-1:0]  good_prod, total_prod;
  logic               verdict;

  always_comb begin
    spw     = (regs.samples_per_window == '0) ? SPW_W'(1) : regs.samples_per_window;
    two_spw = {spw, 1'b0};

    if (pos == '0) begin
      f_max_n = '0;  f_max_t_n = '0;
      f_min_n = '1;  f_min_t_n = '0;
      s_max_n = '0;  s_max_t_n = '0;
      s_min_n = '1;  s_min_t_n = '0;
    end else begin
      f_max_n = f_max;  f_max_t_n = f_max_t;
      f_min_n = f_min;  f_min_t_n = f_min_t;
      s_max_n = s_max;  s_max_t_n = s_max_t;
      s_min_n = s_min;  s_min_t_n = s_min_t;
    end

    in_first  = pos < POS_W'(spw);
    in_second = !in_first && (pos < two_spw);

    // Strict compares keep the time at which a peak was first reached.
    if (in_first) begin
      if (sample > f_max_n) begin
        f_max_n = sample;  f_max_t_n = time_ms;
      end
      if (sample < f_min_n) begin
        f_min_n = sample;  f_min_t_n = time_ms;
      end
    end
    if (in_second) begin
      if (sample > s_max_n) begin
        s_max_n = sample;  s_max_t_n = time_ms;
      end
      if (sample < s_min_n) begin
        s_min_n = sample;  s_min_t_n = time_ms;
      end
    end

    // A window shrunk below the position closes a period without absorbing.
    pos_adv  = (in_first || in_second) ? pos + POS_W'(1) : pos;
    done     = pos_adv >= two_spw;
    pos_next = done ? '0 : pos_adv;

    amp0 = f_max_n - f_min_n;
    amp1 = s_max_n - s_min_n;
    imax = s_max_t_n - f_max_t_n;
    imin = s_min_t_n - f_min_t_n;

    valid = done &&
            (CMP_W'(amp0) >= CMP_W'(regs.min_amplitude)) &&
            (CMP_W'(amp0) <= CMP_W'(regs.max_amplitude)) &&
            (CMP_W'(amp1) >= CMP_W'(regs.min_amplitude)) &&
            (CMP_W'(amp1) <= CMP_W'(regs.max_amplitude)) &&
            (imax >= TIME_BITS'(regs.min_interval_ms)) &&
            (imax <= TIME_BITS'(regs.max_interval_ms)) &&
            (imin >= TIME_BITS'(regs.min_interval_ms)) &&
            (imin <= TIME_BITS'(regs.max_interval_ms));

    total_next = (done && total != COUNT_MAX) ? total + COUNT_W'(1) : total;
    good_next  = (valid && good != COUNT_MAX) ? good + COUNT_W'(1) : good;

    good_prod  = PROD_W'(good_next) * PROD_W'(PERCENT_SCALE);
    total_prod = PROD_W'(regs.pass_percent) * PROD_W'(total_next);
    verdict    = (total_next != '0) && (good_prod >= total_prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      total <= '0;
      good  <= '0;
    end else if (step) begin
      pos   <= pos_next;
      total <= total_next;
      good  <= good_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      f_max <= f_max_n;  f_max_t <= f_max_t_n;
      f_min <= f_min_n;  f_min_t <= f_min_t_n;
      s_max <= s_max_n;  s_max_t <= s_max_t_n;
      s_min <= s_min_n;  s_min_t <= s_min_t_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (res_take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      results.period_done       <= done;
      results.period_valid      <= valid;
      results.first_amplitude   <= done ? amp0 : '0;
      results.second_amplitude  <= done ? amp1 : '0;
      results.max_peak_interval <= done ? imax : '0;
      results.min_peak_interval <= done ? imin : '0;
      results.total_periods     <= total_next;
      results.good_periods      <= good_next;
      results.pass_verdict      <= verdict;
    end
  end

  assign results.valid = res_valid;
endmodule

// ===== rtl/core/periodic_signal_quality_checker_top.sv =====
// ----------------------------------------------------------------------------
// periodic_signal_quality_checker_top
// Two-window peak checker for a periodic signal with period statistics.
//
//   Channel   Role     Carries
//   cfg       sink     register index, write data
//   samples   sink     sample, time_ms
//   results   source   period figures, counters, pass verdict
//
// One sample is taken every cycle while the result channel does not stall; a
// result passes through the input register and then the tracker's result
// register, whose update of peaks and counters, one per sample, sets the rate.
// Reset is synchronous and restores the register defaults and zero counters.
// A stalled result holds its register; one more sample waits in the input
// register, and only then does samples.ready fall.
// ----------------------------------------------------------------------------
module periodic_signal_quality_checker_top #(
  parameter int SAMPLE_BITS = psqc_pkg::SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = psqc_pkg::TIME_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  psqc_cfg_if.sink      cfg,
  psqc_sample_if.sink   samples,
  psqc_result_if.source results
);
  import psqc_pkg::*;

  cfg_t                   regs;
  logic                   held_valid;
  logic [SAMPLE_BITS-1:0] held_sample;
  logic [TIME_BITS-1:0]   held_time;
  logic                   res_valid;
  logic                   step;

  assign step = held_valid && (!res_valid || results.ready);

  psqc_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  psqc_in_stage #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .samples     (samples),
    .step        (step),
    .held_valid  (held_valid),
    .held_sample (held_sample),
    .held_time   (held_time)
  );

  psqc_tracker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_tracker (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .step      (step),
    .sample    (held_sample),
    .time_ms   (held_time),
    .res_take  (results.ready),
    .res_valid (res_valid),
    .results   (results)
  );
endmodule

// ===== rtl/core/psqc_checker.sv =====
// ----------------------------------------------------------------------------
// psqc_checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module psqc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic                         period_done,
  input logic                         period_valid,
  input logic                         amp_zero,
  input logic [psqc_pkg::COUNT_W-1:0] total_periods,
  input logic [psqc_pkg::COUNT_W-1:0] good_periods,
  input logic                         pass_verdict
);
  // A result that is not taken stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid)
    else $error("result withdrawn before transfer");

  // Valid periods are a subset of all periods.
  a_good_le_total: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (good_periods <= total_periods))
    else $error("good period count exceeds total");

  // Without a closed period the amplitudes are zero and the period is not valid.
  a_idle_figures: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !period_done) |-> (!period_valid && amp_zero))
    else $error("period figures set without a closed period");

  // A pass needs at least one period.
  a_pass_needs_period: assert property (@(posedge clk) disable iff (rst)
    (res_valid && pass_verdict) |-> (total_periods != '0))
    else $error("pass verdict with no period seen");
endmodule

bind periodic_signal_quality_checker_top psqc_checker u_psqc_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (results.valid),
  .res_ready     (results.ready),
  .period_done   (results.period_done),
  .period_valid  (results.period_valid),
  .amp_zero      ((results.first_amplitude == '0) && (results.second_amplitude == '0)),
  .total_periods (results.total_periods),
  .good_periods  (results.good_periods),
  .pass_verdict  (results.pass_verdict)
);
